@@ hdl/phd_pkg.sv @@
package phd_pkg;

  localparam logic [1:0] MODE_DIGITAL     = 2'd0;
  localparam logic [1:0] MODE_DIGITAL_INV = 2'd1;
  localparam logic [1:0] MODE_LINEAR      = 2'd2;
  localparam logic [1:0] MODE_ANALOG      = 2'd3;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_PH_FILL = 2'd1;
  localparam logic [1:0] ERR_ADDR    = 2'd2;
  localparam logic [1:0] ERR_CORRUPT = 2'd3;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_THR_ONE     = 3'd1;
  localparam logic [2:0] REG_THR_TWO     = 3'd2;
  localparam logic [2:0] REG_THR_THREE   = 3'd3;
  localparam logic [2:0] REG_THR_FOUR    = 3'd4;
  localparam logic [2:0] REG_THR_FIVE    = 3'd5;

  localparam int NUM_THR = 5;

  localparam logic [2:0] LEVEL_TOP   = 3'd5;
  localparam logic [2:0] LAST_WORD   = 3'd5;
  localparam logic [2:0] WORD_COL_HI = 3'd0;
  localparam logic [2:0] WORD_COL_LO = 3'd1;
  localparam logic [2:0] WORD_ROW_HI = 3'd2;
  localparam logic [2:0] WORD_ROW_LO = 3'd3;
  localparam logic [2:0] WORD_ROW_0  = 3'd4;

  localparam logic signed [9:0] ROW_BASE = 10'sd80;

  typedef logic signed [15:0] thr_t;
  typedef thr_t thr_arr_t [NUM_THR];

  localparam thr_arr_t THR_RESET = '{-16'sd1000, -16'sd500, 16'sd0, 16'sd500, 16'sd1000};

  // first bound that the value is below wins; at or above all: top level
  function automatic logic [2:0] classify(input logic signed [16:0] v, input thr_arr_t th);
    logic [2:0] lvl;
    lvl = LEVEL_TOP;
    for (int i = NUM_THR - 1; i >= 0; i--) begin
      if (v < $signed({th[i][15], th[i]})) begin
        lvl = 3'(i);
      end
    end
    return lvl;
  endfunction

  function automatic logic [8:0] base6(input logic [2:0] d2, input logic [2:0] d1,
                                       input logic [2:0] d0);
    return 9'({d2, 5'b0}) + 9'({d2, 2'b0}) + 9'({d1, 2'b0}) + 9'({d1, 1'b0}) + 9'(d0);
  endfunction

  function automatic logic [6:0] dcol(input logic [2:0] c1, input logic [2:0] c0,
                                      input logic r_odd);
    logic [5:0] c;
    c = 6'({c1, 2'b0}) + 6'({c1, 1'b0}) + 6'(c0);
    return {c, 1'b0} + 7'(r_odd);
  endfunction

endpackage

@@ hdl/pixel_hit_decoder.sv @@
// Pixel hit decoder. Takes one 24-bit readout word per clock while in_stall_o is low and
// turns it into row, column, pulse height and error code. Digital and linear modes give
// one result per word; analog mode (3) gives one result per six words, on the sixth.
// Each word is held in the input register and decoded into the result register in a single
// pass. Configuration (mode and five signed analog thresholds) sits on an APB-style port at
// byte addresses 0, 4, ..., 20; the user must write it only while no word is in flight, and
// the block does not enforce this. NUM_ROWS and NUM_COLS set the valid address range.
module pixel_hit_decoder #(
  parameter int NUM_ROWS = 80,
  parameter int NUM_COLS = 52
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        data_word_i,
  input  logic               hit_start_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         pixel_row_o,
  output logic [6:0]         pixel_column_o,
  output logic signed [11:0] pulse_height_o,
  output logic [1:0]         error_code_o
);

  localparam logic signed [9:0] NumRowsS = 10'(NUM_ROWS);
  localparam logic [6:0]        NumCols7 = 7'(NUM_COLS);

  // configuration
  logic [1:0]        mode_q;
  phd_pkg::thr_arr_t th_q;
  logic [2:0]        reg_idx;
  logic [2:0]        thr_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign thr_idx = reg_idx - 3'd1;
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= phd_pkg::MODE_DIGITAL;
      for (int i = 0; i < phd_pkg::NUM_THR; i++) begin
        th_q[i] <= phd_pkg::THR_RESET[i];
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        phd_pkg::REG_MODE: mode_q <= pwdata[1:0];
        phd_pkg::REG_THR_ONE, phd_pkg::REG_THR_TWO, phd_pkg::REG_THR_THREE,
        phd_pkg::REG_THR_FOUR, phd_pkg::REG_THR_FIVE: th_q[thr_idx] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      phd_pkg::REG_MODE: prdata = {30'b0, mode_q};
      phd_pkg::REG_THR_ONE, phd_pkg::REG_THR_TWO, phd_pkg::REG_THR_THREE,
      phd_pkg::REG_THR_FOUR, phd_pkg::REG_THR_FIVE:
        prdata = {{16{th_q[thr_idx][15]}}, th_q[thr_idx]};
      default: prdata = 32'b0;
    endcase
  end

  // input register
  logic        s1_valid_q;
  logic [23:0] w_q;
  logic        start_q;
  logic        s1_go;
  logic        produce;
  logic        in_accept;

  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept | (s1_valid_q & ~s1_go);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      w_q     <= data_word_i;
      start_q <= hit_start_i;
    end
  end

  // analog hit state
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] prev_q, prev_d;
  logic [5:0] col_dig_q, col_dig_d;
  logic [5:0] row_dig_q, row_dig_d;

  logic [2:0]         cnt_eff;
  logic [2:0]         prev_eff;
  logic signed [16:0] sample;
  logic [2:0]         raw_lvl;
  logic signed [3:0]  diff;
  logic signed [16:0] diff_x;
  logic signed [16:0] adj;
  logic [2:0]         lvl;

  assign cnt_eff  = (start_q || cnt_q > phd_pkg::LAST_WORD) ? 3'd0 : cnt_q;
  assign prev_eff = (cnt_eff == 3'd0) ? phd_pkg::LEVEL_TOP : prev_q;
  assign sample   = {{5{w_q[11]}}, w_q[11:0]};
  assign raw_lvl  = phd_pkg::classify(sample, th_q);
  assign diff     = $signed({1'b0, prev_eff}) - $signed({1'b0, raw_lvl});
  assign diff_x   = {{13{diff[3]}}, diff};
  assign adj      = sample - (diff_x <<< 2) - diff_x;
  assign lvl      = phd_pkg::classify(adj, th_q);

  assign produce = (mode_q != phd_pkg::MODE_ANALOG) || (cnt_eff == phd_pkg::LAST_WORD);
  assign s1_go   = s1_valid_q & (~produce | ~out_valid_o | ~out_stall_i);

  always_comb begin
    cnt_d     = cnt_q;
    prev_d    = prev_q;
    col_dig_d = col_dig_q;
    row_dig_d = row_dig_q;
    if (cnt_eff == phd_pkg::LAST_WORD) begin
      cnt_d  = 3'd0;
      prev_d = phd_pkg::LEVEL_TOP;
    end else begin
      cnt_d  = cnt_eff + 3'd1;
      prev_d = lvl;
      case (cnt_eff)
        phd_pkg::WORD_COL_HI: col_dig_d = {lvl, 3'b0};
        phd_pkg::WORD_COL_LO: col_dig_d = {col_dig_q[5:3], lvl};
        phd_pkg::WORD_ROW_HI: row_dig_d = {lvl, 3'b0};
        phd_pkg::WORD_ROW_LO: row_dig_d = {row_dig_q[5:3], lvl};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 3'd0;
      prev_q    <= phd_pkg::LEVEL_TOP;
      col_dig_q <= 6'd0;
      row_dig_q <= 6'd0;
    end else if (s1_go && mode_q == phd_pkg::MODE_ANALOG) begin
      cnt_q     <= cnt_d;
      prev_q    <= prev_d;
      col_dig_q <= col_dig_d;
      row_dig_q <= row_dig_d;
    end
  end

  // decode
  logic [2:0]         inv;
  logic [8:0]         r_dig;
  logic [8:0]         r_ana;
  logic signed [9:0]  row;
  logic [6:0]         col;
  logic signed [11:0] ph;
  logic [1:0]         err;
  logic               bad;
  logic               corrupt_chk;

  assign inv   = (mode_q == phd_pkg::MODE_DIGITAL_INV) ? 3'b111 : 3'b000;
  assign r_dig = phd_pkg::base6(w_q[17:15] ^ inv, w_q[14:12] ^ inv, w_q[11:9] ^ inv);
  assign r_ana = phd_pkg::base6(row_dig_q[5:3], row_dig_q[2:0], prev_eff);

  always_comb begin
    row         = phd_pkg::ROW_BASE - $signed({2'b0, r_dig[8:1]});
    col         = phd_pkg::dcol(w_q[23:21], w_q[20:18], r_dig[0]);
    ph          = {4'b0, w_q[8:5], w_q[3:0]};
    corrupt_chk = 1'b1;
    case (mode_q)
      phd_pkg::MODE_LINEAR: begin
        row = {3'b0, w_q[16:13], w_q[11:9]};
        col = {1'b0, w_q[23:21], w_q[19:17]};
      end
      phd_pkg::MODE_ANALOG: begin
        row         = phd_pkg::ROW_BASE - $signed({2'b0, r_ana[8:1]});
        col         = phd_pkg::dcol(col_dig_q[5:3], col_dig_q[2:0], r_ana[0]);
        ph          = w_q[11:0];
        corrupt_chk = 1'b0;
      end
      default: ;
    endcase

    bad = (row < 10'sd0) || (row >= NumRowsS) || (col >= NumCols7);
    if (!bad) begin
      err = phd_pkg::ERR_OK;
    end else if (corrupt_chk && row == NumRowsS) begin
      err = phd_pkg::ERR_CORRUPT;
    end else begin
      err = phd_pkg::ERR_ADDR;
    end

    if (mode_q != phd_pkg::MODE_ANALOG) begin
      if (w_q[4]) begin
        row = 10'sd0;
        col = 7'd0;
        err = phd_pkg::ERR_PH_FILL;
      end else if (mode_q == phd_pkg::MODE_LINEAR && (w_q[12] || w_q[20])) begin
        row = 10'sd0;
        col = 7'd0;
        err = phd_pkg::ERR_ADDR;
      end
    end
  end

  // result register
  logic out_load;

  assign out_load = s1_go & produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pixel_row_o    <= row[6:0];
      pixel_column_o <= col;
      pulse_height_o <= ph;
      error_code_o   <= err;
    end
  end

endmodule
